@@ src/qfn_pkg.sv @@
// shared types, widths and helpers for the quad face normal unit
`timescale 1ns / 1ps
`default_nettype none
package qfn_pkg;

   localparam int COORD_BITS = 16;
   localparam int EDGE_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * EDGE_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int MAG_BITS   = PROD_BITS;
   localparam int NORM_BITS  = 31;
   localparam int LEN_BITS   = $clog2(MAG_BITS + 1);
   localparam int SQ_BITS    = 2 * NORM_BITS;
   localparam int SUM_BITS   = SQ_BITS + 2;
   localparam int ROOT_BITS  = SUM_BITS / 2;
   localparam int OUT_BITS   = 16;
   localparam int OUT_FRAC   = 14;
   localparam int QUOT_BITS  = OUT_FRAC + 1;
   localparam int NUM_BITS   = NORM_BITS + OUT_FRAC + 1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] corner0_x;
      logic signed [COORD_BITS-1:0] corner0_y;
      logic signed [COORD_BITS-1:0] corner0_z;
      logic signed [COORD_BITS-1:0] corner1_x;
      logic signed [COORD_BITS-1:0] corner1_y;
      logic signed [COORD_BITS-1:0] corner1_z;
      logic signed [COORD_BITS-1:0] corner3_x;
      logic signed [COORD_BITS-1:0] corner3_y;
      logic signed [COORD_BITS-1:0] corner3_z;
      logic                         last_face;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] normal_x;
      logic signed [OUT_BITS-1:0] normal_y;
      logic signed [OUT_BITS-1:0] normal_z;
      logic                       degenerate;
      logic                       face_end;
   } rsp_type;

   typedef struct packed {
      logic [2:0][MAG_BITS-1:0] mag;
      logic [2:0]               neg;
      logic                     last;
   } cross_type;

   typedef struct packed {
      logic [2:0][NORM_BITS-1:0] m;
      logic [2:0]                neg;
      logic                      degen;
      logic                      last;
   } side_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] sum;
      side_type            side;
   } sq_type;

   typedef struct packed {
      logic [ROOT_BITS-1:0] root;
      side_type             side;
   } rt_type;

   typedef struct packed {
      logic [2:0][QUOT_BITS-1:0] q;
      logic [2:0]                neg;
      logic                      degen;
      logic                      last;
   } qt_type;

   function automatic logic [LEN_BITS-1:0] bit_len(input logic [MAG_BITS-1:0] v);
      logic [LEN_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < MAG_BITS; i++) begin
         if (v[i]) n = LEN_BITS'(i + 1);
      end
      return n;
   endfunction

endpackage
`default_nettype wire

@@ src/quad_face_normal_unit.sv @@
// top level: quad face unit normal pipeline with output register
// throughput: one face per cycle; the whole pipeline holds while the output waits
// the depth is set by the 32-stage square root and the 16-stage divider
// reset clears all valid bits; data registers are not cleared, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module quad_face_normal_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire qfn_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output qfn_pkg::rsp_type      rsp_data
);

   logic               adv;
   logic               cross_valid;
   qfn_pkg::cross_type cross_data;
   logic               norm_valid;
   qfn_pkg::sq_type    norm_data;
   logic               sqrt_valid;
   qfn_pkg::rt_type    sqrt_data;
   logic               div_valid;
   qfn_pkg::qt_type    div_data;
   logic               rsp_valid_ff;
   qfn_pkg::rsp_type   rsp_data_ff;
   qfn_pkg::rsp_type   rsp_data_in;
   logic [2:0][qfn_pkg::OUT_BITS-1:0] n_in;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   qfn_cross u_cross (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_valid && req_ready), .in_data(req_data),
      .out_valid(cross_valid), .out_data(cross_data)
   );

   qfn_norm u_norm (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(cross_valid), .in_data(cross_data),
      .out_valid(norm_valid), .out_data(norm_data)
   );

   qfn_sqrt u_sqrt (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(norm_valid), .in_data(norm_data),
      .out_valid(sqrt_valid), .out_data(sqrt_data)
   );

   qfn_div u_div (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(sqrt_valid), .in_data(sqrt_data),
      .out_valid(div_valid), .out_data(div_data)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (div_data.degen) begin
            n_in[i] = '0;
         end else if (div_data.neg[i]) begin
            n_in[i] = qfn_pkg::OUT_BITS'(-qfn_pkg::OUT_BITS'(div_data.q[i]));
         end else begin
            n_in[i] = qfn_pkg::OUT_BITS'(div_data.q[i]);
         end
      end
      rsp_data_in.normal_x   = n_in[0];
      rsp_data_in.normal_y   = n_in[1];
      rsp_data_in.normal_z   = n_in[2];
      rsp_data_in.degenerate = div_data.degen;
      rsp_data_in.face_end   = div_data.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.normal_x == '0 && rsp_data.normal_y == '0 && rsp_data.normal_z == '0)
      else $error("degenerate response with nonzero normal");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.normal_x >= -16'sd16384 && rsp_data.normal_x <= 16'sd16384
         && rsp_data.normal_y >= -16'sd16384 && rsp_data.normal_y <= 16'sd16384
         && rsp_data.normal_z >= -16'sd16384 && rsp_data.normal_z <= 16'sd16384)
      else $error("normal component out of unit range");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output stall");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response lost or changed");

endmodule
`default_nettype wire

@@ src/qfn_cross.sv @@
// edge vectors, exact cross product and sign/magnitude split
`timescale 1ns / 1ps
`default_nettype none
module qfn_cross (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire qfn_pkg::req_type  in_data,
   output logic                   out_valid,
   output qfn_pkg::cross_type     out_data
);

   logic signed [qfn_pkg::EDGE_BITS-1:0]  ea_ff [3];
   logic signed [qfn_pkg::EDGE_BITS-1:0]  eb_ff [3];
   logic signed [qfn_pkg::EDGE_BITS-1:0]  ea_in [3];
   logic signed [qfn_pkg::EDGE_BITS-1:0]  eb_in [3];
   logic signed [qfn_pkg::PROD_BITS-1:0]  p_ff  [6];
   logic signed [qfn_pkg::CROSS_BITS-1:0] d_ff  [3];
   qfn_pkg::cross_type                    res_ff;
   logic [3:0]                            v_ff;
   logic [2:0]                            last_ff;

   always_comb begin
      ea_in[0] = qfn_pkg::EDGE_BITS'(in_data.corner1_x) - qfn_pkg::EDGE_BITS'(in_data.corner0_x);
      ea_in[1] = qfn_pkg::EDGE_BITS'(in_data.corner1_y) - qfn_pkg::EDGE_BITS'(in_data.corner0_y);
      ea_in[2] = qfn_pkg::EDGE_BITS'(in_data.corner1_z) - qfn_pkg::EDGE_BITS'(in_data.corner0_z);
      eb_in[0] = qfn_pkg::EDGE_BITS'(in_data.corner3_x) - qfn_pkg::EDGE_BITS'(in_data.corner0_x);
      eb_in[1] = qfn_pkg::EDGE_BITS'(in_data.corner3_y) - qfn_pkg::EDGE_BITS'(in_data.corner0_y);
      eb_in[2] = qfn_pkg::EDGE_BITS'(in_data.corner3_z) - qfn_pkg::EDGE_BITS'(in_data.corner0_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ea_ff      <= ea_in;
         eb_ff      <= eb_in;
         last_ff[0] <= in_data.last_face;
         p_ff[0]    <= eb_ff[1] * ea_ff[2];
         p_ff[1]    <= eb_ff[2] * ea_ff[1];
         p_ff[2]    <= eb_ff[2] * ea_ff[0];
         p_ff[3]    <= eb_ff[0] * ea_ff[2];
         p_ff[4]    <= eb_ff[0] * ea_ff[1];
         p_ff[5]    <= eb_ff[1] * ea_ff[0];
         last_ff[1] <= last_ff[0];
         for (int i = 0; i < 3; i++) begin
            d_ff[i] <= qfn_pkg::CROSS_BITS'(p_ff[2*i]) - qfn_pkg::CROSS_BITS'(p_ff[2*i+1]);
         end
         last_ff[2] <= last_ff[1];
         for (int i = 0; i < 3; i++) begin
            res_ff.neg[i] <= d_ff[i][qfn_pkg::CROSS_BITS-1];
            res_ff.mag[i] <= d_ff[i][qfn_pkg::CROSS_BITS-1]
                             ? qfn_pkg::MAG_BITS'(-d_ff[i]) : qfn_pkg::MAG_BITS'(d_ff[i]);
         end
         res_ff.last <= last_ff[2];
      end
   end

   assign out_valid = v_ff[3];
   assign out_data  = res_ff;

endmodule
`default_nettype wire

@@ src/qfn_norm.sv @@
// common scaling of the cross magnitudes and sum of squares
`timescale 1ns / 1ps
`default_nettype none
module qfn_norm (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire qfn_pkg::cross_type in_data,
   output logic                    out_valid,
   output qfn_pkg::sq_type         out_data
);

   qfn_pkg::cross_type                  c_ff;
   logic [qfn_pkg::LEN_BITS-1:0]        blen_ff;
   qfn_pkg::side_type                   s1_ff;
   qfn_pkg::side_type                   s2_ff;
   logic [2:0][qfn_pkg::SQ_BITS-1:0]    sq_ff;
   qfn_pkg::sq_type                     res_ff;
   qfn_pkg::side_type                   s_in;
   logic [qfn_pkg::LEN_BITS-1:0]        rsh;
   logic [qfn_pkg::LEN_BITS-1:0]        lsh;
   logic [3:0]                          v_ff;

   always_comb begin
      rsh = blen_ff - qfn_pkg::LEN_BITS'(qfn_pkg::NORM_BITS);
      lsh = qfn_pkg::LEN_BITS'(qfn_pkg::NORM_BITS) - blen_ff;
      s_in.neg   = c_ff.neg;
      s_in.last  = c_ff.last;
      s_in.degen = (blen_ff == '0);
      for (int i = 0; i < 3; i++) begin
         if (blen_ff > qfn_pkg::LEN_BITS'(qfn_pkg::NORM_BITS)) begin
            s_in.m[i] = qfn_pkg::NORM_BITS'(c_ff.mag[i] >> rsh);
         end else begin
            s_in.m[i] = qfn_pkg::NORM_BITS'({30'd0, c_ff.mag[i]} << lsh);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff    <= in_data;
         blen_ff <= qfn_pkg::bit_len(in_data.mag[0] | in_data.mag[1] | in_data.mag[2]);
         s1_ff   <= s_in;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= qfn_pkg::SQ_BITS'(s1_ff.m[i]) * qfn_pkg::SQ_BITS'(s1_ff.m[i]);
         end
         s2_ff      <= s1_ff;
         res_ff.sum <= qfn_pkg::SUM_BITS'(sq_ff[0]) + qfn_pkg::SUM_BITS'(sq_ff[1])
                       + qfn_pkg::SUM_BITS'(sq_ff[2]);
         res_ff.side <= s2_ff;
      end
   end

   assign out_valid = v_ff[3];
   assign out_data  = res_ff;

endmodule
`default_nettype wire

@@ src/qfn_sqrt.sv @@
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module qfn_sqrt (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            adv,
   input  wire logic            in_valid,
   input  wire qfn_pkg::sq_type in_data,
   output logic                 out_valid,
   output qfn_pkg::rt_type      out_data
);

   localparam int NST = qfn_pkg::ROOT_BITS;

   logic [qfn_pkg::SUM_BITS-1:0]  rem_ff  [NST];
   logic [qfn_pkg::ROOT_BITS-1:0] root_ff [NST];
   qfn_pkg::side_type             side_ff [NST];
   logic [NST-1:0]                v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NST-2:0], in_valid};
      end
   end

   for (genvar s = 0; s < NST; s++) begin : g_stage
      localparam int K = NST - 1 - s;
      logic [qfn_pkg::SUM_BITS-1:0]  rem_prev;
      logic [qfn_pkg::ROOT_BITS-1:0] root_prev;
      qfn_pkg::side_type             side_prev;
      logic [qfn_pkg::SUM_BITS+1:0]  trial;

      if (s == 0) begin : g_first
         assign rem_prev  = in_data.sum;
         assign root_prev = '0;
         assign side_prev = in_data.side;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      assign trial = ((qfn_pkg::SUM_BITS+2)'(root_prev) << (K + 1))
                     + ((qfn_pkg::SUM_BITS+2)'(1) << (2 * K));

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[s] <= side_prev;
            if (trial <= (qfn_pkg::SUM_BITS+2)'(rem_prev)) begin
               rem_ff[s]  <= rem_prev - qfn_pkg::SUM_BITS'(trial);
               root_ff[s] <= root_prev | (qfn_pkg::ROOT_BITS'(1) << K);
            end else begin
               rem_ff[s]  <= rem_prev;
               root_ff[s] <= root_prev;
            end
         end
      end
   end

   assign out_valid     = v_ff[NST-1];
   assign out_data.root = root_ff[NST-1];
   assign out_data.side = side_ff[NST-1];

endmodule
`default_nettype wire

@@ src/qfn_div.sv @@
// pipelined restoring divide of scaled components by the length
`timescale 1ns / 1ps
`default_nettype none
module qfn_div (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            adv,
   input  wire logic            in_valid,
   input  wire qfn_pkg::rt_type in_data,
   output logic                 out_valid,
   output qfn_pkg::qt_type      out_data
);

   localparam int NST = qfn_pkg::QUOT_BITS;

   logic [2:0][qfn_pkg::NUM_BITS-1:0]  num_ff;
   logic [qfn_pkg::ROOT_BITS-1:0]      len_ff;
   qfn_pkg::side_type                  side0_ff;
   logic                               v0_ff;
   logic [2:0][qfn_pkg::NUM_BITS-1:0]  rem_ff  [NST];
   logic [2:0][qfn_pkg::QUOT_BITS-1:0] q_ff    [NST];
   logic [qfn_pkg::ROOT_BITS-1:0]      lenp_ff [NST];
   qfn_pkg::side_type                  side_ff [NST];
   logic [NST-1:0]                     v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v_ff  <= '0;
      end else if (adv) begin
         v0_ff <= in_valid;
         v_ff  <= {v_ff[NST-2:0], v0_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= (qfn_pkg::NUM_BITS'(in_data.side.m[i]) << qfn_pkg::OUT_FRAC)
                         + qfn_pkg::NUM_BITS'(in_data.root >> 1);
         end
         len_ff   <= in_data.root;
         side0_ff <= in_data.side;
      end
   end

   for (genvar s = 0; s < NST; s++) begin : g_stage
      localparam int K = NST - 1 - s;
      logic [2:0][qfn_pkg::NUM_BITS-1:0]  rem_prev;
      logic [2:0][qfn_pkg::QUOT_BITS-1:0] q_prev;
      logic [qfn_pkg::ROOT_BITS-1:0]      len_prev;
      qfn_pkg::side_type                  side_prev;
      logic [qfn_pkg::NUM_BITS:0]         dsr;

      if (s == 0) begin : g_first
         assign rem_prev  = num_ff;
         assign q_prev    = '0;
         assign len_prev  = len_ff;
         assign side_prev = side0_ff;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign q_prev    = q_ff[s-1];
         assign len_prev  = lenp_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      assign dsr = (qfn_pkg::NUM_BITS+1)'(len_prev) << K;

      always_ff @(posedge clock) begin
         if (adv) begin
            lenp_ff[s] <= len_prev;
            side_ff[s] <= side_prev;
            for (int i = 0; i < 3; i++) begin
               if ((qfn_pkg::NUM_BITS+1)'(rem_prev[i]) >= dsr) begin
                  rem_ff[s][i] <= rem_prev[i] - qfn_pkg::NUM_BITS'(dsr);
                  q_ff[s][i]   <= q_prev[i] | (qfn_pkg::QUOT_BITS'(1) << K);
               end else begin
                  rem_ff[s][i] <= rem_prev[i];
                  q_ff[s][i]   <= q_prev[i];
               end
            end
         end
      end
   end

   assign out_valid      = v_ff[NST-1];
   assign out_data.q     = q_ff[NST-1];
   assign out_data.neg   = side_ff[NST-1].neg;
   assign out_data.degen = side_ff[NST-1].degen;
   assign out_data.last  = side_ff[NST-1].last;

endmodule
`default_nettype wire

@@ tb/qfn_checker.sv @@
// checker: predicts the unit normal of each accepted face and compares responses
`timescale 1ns / 1ps
`default_nettype none
module qfn_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire qfn_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire qfn_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    normals_pending
);

   qfn_pkg::rsp_type normal_queue[$];

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic qfn_pkg::rsp_type face_normal(input qfn_pkg::req_type f);
      longint ea[3];
      longint eb[3];
      longint cr[3];
      logic [63:0] mag[3];
      logic [63:0] m[3];
      logic [63:0] sum;
      logic [63:0] len;
      logic [63:0] q;
      logic [15:0] comp[3];
      int top;
      qfn_pkg::rsp_type r;
      ea[0] = longint'($signed(f.corner1_x)) - longint'($signed(f.corner0_x));
      ea[1] = longint'($signed(f.corner1_y)) - longint'($signed(f.corner0_y));
      ea[2] = longint'($signed(f.corner1_z)) - longint'($signed(f.corner0_z));
      eb[0] = longint'($signed(f.corner3_x)) - longint'($signed(f.corner0_x));
      eb[1] = longint'($signed(f.corner3_y)) - longint'($signed(f.corner0_y));
      eb[2] = longint'($signed(f.corner3_z)) - longint'($signed(f.corner0_z));
      cr[0] = eb[1] * ea[2] - eb[2] * ea[1];
      cr[1] = eb[2] * ea[0] - eb[0] * ea[2];
      cr[2] = eb[0] * ea[1] - eb[1] * ea[0];
      top = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (cr[i] < 0) ? 64'(-cr[i]) : 64'(cr[i]);
         for (int k = 0; k < 64; k++) begin
            if (mag[i][k] && k + 1 > top) top = k + 1;
         end
      end
      r = '0;
      r.face_end = f.last_face;
      if (top == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (top > qfn_pkg::NORM_BITS) ? (mag[i] >> (top - qfn_pkg::NORM_BITS))
                                           : (mag[i] << (qfn_pkg::NORM_BITS - top));
         sum = sum + m[i] * m[i];
      end
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (m[i] * 64'd16384 + (len >> 1)) / len;
         if (cr[i] < 0) q = -q;
         comp[i] = q[15:0];
      end
      r.normal_x = comp[0];
      r.normal_y = comp[1];
      r.normal_z = comp[2];
      return r;
   endfunction

   assign normals_pending = normal_queue.size();

   always @(posedge clock) begin
      qfn_pkg::rsp_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) normal_queue.push_back(face_normal(req_data));
         if (rsp_valid && rsp_ready) begin
            if (normal_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = normal_queue.pop_front();
               if (rsp_data !== want) begin
                  if (fail_count < 10)
                     $display({"mismatch: expected x=%0d y=%0d z=%0d dg=%0b fe=%0b,",
                               " got x=%0d y=%0d z=%0d dg=%0b fe=%0b"},
                        want.normal_x, want.normal_y, want.normal_z, want.degenerate,
                        want.face_end, rsp_data.normal_x, rsp_data.normal_y,
                        rsp_data.normal_z, rsp_data.degenerate, rsp_data.face_end);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// testbench top: face stimulus, random idling and the final verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   qfn_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   qfn_pkg::rsp_type rsp_data;
   int               fail_count;
   int               normals_pending;
   logic             no_idle = 1'b0;
   int               cycle_count = 0;

   quad_face_normal_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   qfn_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .normals_pending(normals_pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 38);
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [15:0] rand_coord(input int mode);
      case (mode)
         0: begin
            return 16'($urandom);
         end
         1: begin
            return 16'($urandom_range(16) - 8);
         end
         default: begin
            return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
         end
      endcase
   endfunction

   task automatic send_face(input qfn_pkg::req_type f);
      req_valid <= 1'b1;
      req_data <= f;
      do @(posedge clock); while (!req_ready);
      if (!no_idle && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic send_corners(input logic [15:0] a[9], input logic lf);
      qfn_pkg::req_type f;
      f = {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8], lf};
      send_face(f);
   endtask

   initial begin
      qfn_pkg::req_type f;
      logic [15:0] c[9];
      logic [159:0] raw;
      int mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // degenerate: all corners equal, then collinear
      c = '{default: 16'h0};
      send_corners(c, 1'b0);
      c = '{default: 16'h8000};
      send_corners(c, 1'b1);
      c = '{16'd0, 16'd0, 16'd0, 16'd256, 16'd256, 16'd256,
            16'd512, 16'd512, 16'd512};
      send_corners(c, 1'b0);
      // axis-aligned faces
      c = '{16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0};
      send_corners(c, 1'b0);
      c = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0, 16'd0, 16'd256};
      send_corners(c, 1'b1);
      c = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd256, 16'd0, 16'd0};
      send_corners(c, 1'b0);
      // tiny and extreme edges
      c = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0};
      send_corners(c, 1'b0);
      c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
            16'h8000, 16'h7fff, 16'h8000};
      send_corners(c, 1'b1);
      c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
            16'h8000, 16'h7fff, 16'h7fff};
      send_corners(c, 1'b0);
      c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
            16'h8000, 16'h8000, 16'h7fff};
      send_corners(c, 1'b1);
      for (int i = 0; i < 10; i++) begin
         foreach (c[k]) c[k] = rand_coord(2);
         send_corners(c, 1'($urandom));
      end
      for (int n = 0; n < 700; n++) begin
         no_idle <= (n >= 300 && n < 400);
         mode = $urandom_range(9);
         if (mode < 6) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
            f = raw[$bits(qfn_pkg::req_type)-1:0];
         end else if (mode < 8) begin
            foreach (c[k]) c[k] = rand_coord(1);
            f = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], 1'($urandom)};
         end else begin
            // collinear corners for zero cross product
            foreach (c[k]) c[k] = (k < 3) ? rand_coord(1) : 16'd0;
            for (int k = 0; k < 3; k++) begin
               c[3 + k] = c[k] + 16'($urandom_range(4));
               c[6 + k] = c[k] + 16'd2 * (c[3 + k] - c[k]);
            end
            f = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], 1'($urandom)};
         end
         send_face(f);
      end
      req_valid <= 1'b0;
      no_idle <= 1'b0;
      while (normals_pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
src/qfn_pkg.sv
src/qfn_cross.sv
src/qfn_norm.sv
src/qfn_sqrt.sv
src/qfn_div.sv
src/quad_face_normal_unit.sv
tb/qfn_checker.sv
tb/tb_top.sv
